// ----- rtl/dcm_pkg.sv -----
// Shared types and constants for the multichannel duty cycle meter.
`default_nettype none

package dcm_pkg;

  localparam int DEF_MAX_CHANNELS = 8;
  localparam int DEF_COUNT_BITS   = 16;

  localparam int QUEUE_DEPTH    = 2;
  localparam int QUEUE_PTR_BITS = 1;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_PERIOD = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOWS       = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_COUNT = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RESULT_GAIN   = 2'd3;

  localparam logic [15:0] RST_WINDOW_PERIOD = 16'd4000;
  localparam logic [4:0]  RST_WINDOWS       = 5'd2;
  localparam logic [3:0]  RST_CHANNEL_COUNT = 4'd3;
  localparam logic [15:0] RST_RESULT_GAIN   = 16'd507;

  typedef struct packed {
    logic [15:0] window_period_us;
    logic [4:0]  windows_per_channel;
    logic [3:0]  channel_count;
    logic [15:0] result_gain_q8;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_us;
    logic [7:0]  pin_levels;
  } item_t;

  typedef struct packed {
    logic [2:0]  channel;
    logic [23:0] duty_value;
    logic        sweep_last;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/dcm_fifo.sv -----
// Two-entry queue used between the front end, the measurement engine and the result port.
`default_nettype none

module dcm_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  empty
);

  logic [WIDTH-1:0] mem [dcm_pkg::QUEUE_DEPTH];
  logic [dcm_pkg::QUEUE_PTR_BITS-1:0] wptr;
  logic [dcm_pkg::QUEUE_PTR_BITS-1:0] rptr;
  logic [dcm_pkg::QUEUE_PTR_BITS:0]   count;
  logic do_push;
  logic do_pop;

  assign full    = (count == (dcm_pkg::QUEUE_PTR_BITS+1)'(dcm_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dcm_core.sv -----
// Measurement engine: window timing, low-sample counting, averaging divider and gain.
`default_nettype none

module dcm_core #(
  parameter int MAX_CHANNELS = dcm_pkg::DEF_MAX_CHANNELS,
  parameter int COUNT_BITS   = dcm_pkg::DEF_COUNT_BITS
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire dcm_pkg::cfg_t   cfg,
  input  wire logic            in_valid,
  input  wire dcm_pkg::item_t  item,
  output logic                 in_pop,
  input  wire logic            out_full,
  output logic                 out_push,
  output dcm_pkg::result_t     result
);

  localparam int IW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SW  = COUNT_BITS + 4;
  localparam int DCW = $clog2(SW + 1);
  localparam int PW  = SW + 16;
  localparam int XW  = (PW > 32) ? PW : 33;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t state;

  logic                  measuring;
  logic [IW-1:0]         channel_index;
  logic [31:0]           window_start;
  logic [COUNT_BITS-1:0] low_samples;
  logic [4:0]            windows_done;
  logic [SW-1:0]         window_sum;

  logic [SW-1:0]   quo;
  logic [4:0]      rem;
  logic [4:0]      divisor;
  logic [DCW-1:0]  div_count;
  logic [15:0]     gain;
  logic [PW-1:0]   product;
  logic [2:0]      res_channel;
  logic            res_last;

  logic [4:0]      nwin;
  logic [5:0]      cnt6;
  logic [5:0]      nch;
  logic [31:0]     elapsed;
  logic            in_window;
  logic            pin_low;
  logic [SW:0]     sum_wide;
  logic [SW-1:0]   sum_sat;
  logic [4:0]      wd_inc;
  logic            last;
  logic [5:0]      trial;
  logic [XW-1:0]   prod_x;

  always_comb begin
    if (cfg.windows_per_channel == 5'd0) begin
      nwin = 5'd1;
    end else if (cfg.windows_per_channel > 5'd16) begin
      nwin = 5'd16;
    end else begin
      nwin = cfg.windows_per_channel;
    end
    cnt6 = 6'(cfg.channel_count);
    if (cnt6 == 6'd0) begin
      nch = 6'd1;
    end else if (cnt6 > 6'(MAX_CHANNELS)) begin
      nch = 6'(MAX_CHANNELS);
    end else begin
      nch = cnt6;
    end
  end

  assign elapsed   = item.now_us - window_start;
  assign in_window = elapsed < {16'd0, cfg.window_period_us};
  assign pin_low   = (6'(channel_index) < 6'd8) && !item.pin_levels[3'(channel_index)];
  assign sum_wide  = (SW+1)'(window_sum) + (SW+1)'(low_samples);
  assign sum_sat   = sum_wide[SW] ? '1 : sum_wide[SW-1:0];
  assign wd_inc    = (windows_done == 5'd31) ? windows_done : windows_done + 5'd1;
  assign last      = (7'(channel_index) + 7'd1) >= 7'(nch);
  assign trial     = {rem, quo[SW-1]};
  assign prod_x    = XW'(product);

  assign in_pop   = (state == ST_IDLE) && in_valid;
  assign out_push = (state == ST_OUT) && !out_full;

  always_comb begin
    result.channel    = res_channel;
    result.sweep_last = res_last;
    result.duty_value = (prod_x[XW-1:32] != '0) ? 24'hFFFFFF : prod_x[31:8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      measuring     <= 1'b0;
      channel_index <= '0;
      window_start  <= '0;
      low_samples   <= '0;
      windows_done  <= '0;
      window_sum    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (!measuring) begin
              window_start <= item.now_us;
              measuring    <= 1'b1;
            end else if (in_window) begin
              if (pin_low && (low_samples != '1)) begin
                low_samples <= low_samples + 1'b1;
              end
            end else begin
              window_start <= item.now_us;
              low_samples  <= '0;
              if (wd_inc < nwin) begin
                window_sum   <= sum_sat;
                windows_done <= wd_inc;
              end else begin
                window_sum    <= '0;
                windows_done  <= '0;
                measuring     <= 1'b0;
                channel_index <= last ? '0 : channel_index + 1'b1;
                state         <= ST_DIV;
              end
            end
          end
        end
        ST_DIV: begin
          if (div_count == DCW'(1)) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_full) begin
            state <= ST_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        quo         <= sum_sat;
        rem         <= '0;
        divisor     <= nwin;
        div_count   <= DCW'(SW);
        gain        <= cfg.result_gain_q8;
        res_channel <= 3'(channel_index);
        res_last    <= last;
      end
      ST_DIV: begin
        if (trial >= {1'b0, divisor}) begin
          rem <= 5'(trial - {1'b0, divisor});
          quo <= {quo[SW-2:0], 1'b1};
        end else begin
          rem <= trial[4:0];
          quo <= {quo[SW-2:0], 1'b0};
        end
        div_count <= div_count - 1'b1;
      end
      ST_MUL: begin
        product <= PW'(quo) * PW'(gain);
      end
      ST_OUT: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/multichannel_duty_cycle_meter.sv -----
// Top level of the multichannel duty cycle meter.
//
// Each pushed transaction is one sampling call (timestamp and pin levels) and lands in a
// two-entry input queue; the measurement engine drains it one call per cycle while the
// call only opens, extends or closes a window. The call that completes a channel holds
// the engine while it takes the call, runs the bit-serial divide of the window sum by the
// window count, applies the gain multiply and writes the two-entry result queue, waiting
// while that queue is full. Results are popped from the result queue; sweep_last marks
// the final channel of each sweep.
`default_nettype none

module multichannel_duty_cycle_meter #(
  parameter int MAX_CHANNELS = dcm_pkg::DEF_MAX_CHANNELS,
  parameter int COUNT_BITS   = dcm_pkg::DEF_COUNT_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [dcm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [dcm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic [31:0]                         now_us,
  input  wire logic [7:0]                          pin_levels,
  output logic                                     empty,
  input  wire logic                                pop,
  output logic      [2:0]                          channel,
  output logic      [23:0]                         duty_value,
  output logic                                     sweep_last
);

  dcm_pkg::cfg_t    cfg;
  dcm_pkg::item_t   in_item;
  dcm_pkg::item_t   q_item;
  dcm_pkg::result_t core_res;
  dcm_pkg::result_t out_res;
  logic             in_empty;
  logic             in_pop;
  logic             out_full;
  logic             out_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_period_us    <= dcm_pkg::RST_WINDOW_PERIOD;
      cfg.windows_per_channel <= dcm_pkg::RST_WINDOWS;
      cfg.channel_count       <= dcm_pkg::RST_CHANNEL_COUNT;
      cfg.result_gain_q8      <= dcm_pkg::RST_RESULT_GAIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dcm_pkg::REG_WINDOW_PERIOD: cfg.window_period_us    <= cfg_data;
        dcm_pkg::REG_WINDOWS:       cfg.windows_per_channel <= cfg_data[4:0];
        dcm_pkg::REG_CHANNEL_COUNT: cfg.channel_count       <= cfg_data[3:0];
        dcm_pkg::REG_RESULT_GAIN:   cfg.result_gain_q8      <= cfg_data;
      endcase
    end
  end

  assign in_item.now_us     = now_us;
  assign in_item.pin_levels = pin_levels;

  dcm_fifo #(
    .WIDTH($bits(dcm_pkg::item_t))
  ) u_in_q (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (in_item),
    .full (full),
    .pop  (in_pop),
    .dout (q_item),
    .empty(in_empty)
  );

  dcm_core #(
    .MAX_CHANNELS(MAX_CHANNELS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_valid(!in_empty),
    .item    (q_item),
    .in_pop  (in_pop),
    .out_full(out_full),
    .out_push(out_push),
    .result  (core_res)
  );

  dcm_fifo #(
    .WIDTH($bits(dcm_pkg::result_t))
  ) u_out_q (
    .clk  (clk),
    .rst  (rst),
    .push (out_push),
    .din  (core_res),
    .full (out_full),
    .pop  (pop),
    .dout (out_res),
    .empty(empty)
  );

  assign channel    = out_res.channel;
  assign duty_value = out_res.duty_value;
  assign sweep_last = out_res.sweep_last;

endmodule

`default_nettype wire

// ----- rtl/dcm_checker.sv -----
// Port-level checks for the multichannel duty cycle meter, bound to the top level.
`default_nettype none

module dcm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        push,
  input wire logic        full,
  input wire logic        pop,
  input wire logic        empty,
  input wire logic [2:0]  channel,
  input wire logic [23:0] duty_value,
  input wire logic        sweep_last
);

  a_reset_queues: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not cleared by reset");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    $fell(empty) |-> !$past(rst) && !$past(rst, 2))
    else $error("result appeared too soon after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(channel) && $stable(duty_value)
                       && $stable(sweep_last))
    else $error("waiting result changed");

  a_full_needs_push: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push))
    else $error("input queue filled without a push");

endmodule

bind multichannel_duty_cycle_meter dcm_checker u_dcm_checker (
  .clk       (clk),
  .rst       (rst),
  .push      (push),
  .full      (full),
  .pop       (pop),
  .empty     (empty),
  .channel   (channel),
  .duty_value(duty_value),
  .sweep_last(sweep_last)
);

`default_nettype wire
